[hw/rtl/block_transfer_address_sequencer_core_assert.svh]
// Assertion helpers for the checker module.
`ifndef BLOCK_TRANSFER_ADDRESS_SEQUENCER_CORE_ASSERT_SVH
`define BLOCK_TRANSFER_ADDRESS_SEQUENCER_CORE_ASSERT_SVH

// Same-cycle implication.
`define BTAS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("btas assertion failed");

// Next-cycle implication.
`define BTAS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("btas assertion failed");

`endif

[hw/rtl/btas_pkg.sv]
`timescale 1ns / 1ps

package btas_pkg;

  localparam int NUM_REGS_DEF = 16;
  localparam int REG_W        = 4;
  localparam int ADDR_W       = 32;
  localparam int S_TDATA_W    = 56;
  localparam int M_TDATA_W    = 40;

  typedef enum logic [1:0] {
    KIND_LOAD,
    KIND_STORE,
    KIND_WB
  } kind_t;

  typedef enum logic [1:0] {
    STEP_ACCEPT,
    STEP_SCAN,
    STEP_WB
  } step_t;

  typedef enum logic [1:0] {
    JC_ALWAYS,
    JC_ACCEPT,
    JC_SCAN_DONE
  } jcond_t;

  typedef struct packed {
    logic   take_in;
    logic   emit_xfer;
    logic   emit_wb;
    jcond_t cond;
    step_t  target;
  } ucode_t;

  typedef struct packed {
    logic accept;
    logic scan_done;
    logic stall;
  } useq_stat_t;

  function automatic ucode_t ucode_rom(step_t s);
    ucode_t w;
    unique case (s)
      STEP_ACCEPT: w = '{take_in: 1'b1, emit_xfer: 1'b0, emit_wb: 1'b0,
                         cond: JC_ACCEPT, target: STEP_SCAN};
      STEP_SCAN:   w = '{take_in: 1'b0, emit_xfer: 1'b1, emit_wb: 1'b0,
                         cond: JC_SCAN_DONE, target: STEP_WB};
      STEP_WB:     w = '{take_in: 1'b0, emit_xfer: 1'b0, emit_wb: 1'b1,
                         cond: JC_ALWAYS, target: STEP_ACCEPT};
      default:     w = '{take_in: 1'b0, emit_xfer: 1'b0, emit_wb: 1'b0,
                         cond: JC_ALWAYS, target: STEP_ACCEPT};
    endcase
    return w;
  endfunction

endpackage

[hw/rtl/block_transfer_address_sequencer_core.sv]
`timescale 1ns / 1ps

// Block load/store address sequencer. Each request word expands into one
// transfer word per selected register (ascending or descending order, word
// addresses stepping by four) and, with writeback, a final word carrying the
// new base value; tlast marks the final word of a request, and a request with
// an empty list and no writeback produces nothing. A three-step microcode
// program runs each request: an accept step, a scan step that walks one
// register position per cycle, unless the output stalls, from the first
// position in walk order up to the last selected register (at least one),
// then a writeback step. Output backpressure stalls the scan and writeback
// steps.

module block_transfer_address_sequencer_core #(
  parameter int NUM_REGS = btas_pkg::NUM_REGS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // base_value, base_reg, reg_mask, pre_index, up, writeback, pad
  input  logic [btas_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // op
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // reg_index, address_or_value, pad
  output logic [btas_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // kind
  output logic [1:0]                     m_axis_tuser,
  output logic                           m_axis_tlast
);

  localparam int PW = $clog2(NUM_REGS);
  localparam int CW = $clog2(NUM_REGS + 1);
  localparam logic [PW-1:0] LAST_POS = PW'(NUM_REGS - 1);

  btas_pkg::ucode_t     ctrl;
  btas_pkg::useq_stat_t stat;

  logic                        op;
  logic [btas_pkg::ADDR_W-1:0] base;
  logic [btas_pkg::REG_W-1:0]  breg;
  logic [NUM_REGS-1:0]         list;
  logic                        up;
  logic                        wb;
  logic [PW-1:0]               pos;
  logic [btas_pkg::ADDR_W-1:0] addr;
  logic [CW-1:0]               count;

  logic                        m_valid;
  btas_pkg::kind_t             m_kind;
  logic [btas_pkg::REG_W-1:0]  m_reg;
  logic [btas_pkg::ADDR_W-1:0] m_addr;
  logic                        m_last;

  logic [btas_pkg::ADDR_W-1:0] in_base;
  logic [btas_pkg::REG_W-1:0]  in_breg;
  logic [15:0]                 in_list;
  logic                        in_pre;
  logic                        in_up;
  logic                        in_wb;

  logic                        accept;
  logic [PW-1:0]               ridx;
  logic                        sel;
  logic [NUM_REGS-1:0]         list_rest;
  logic                        out_free;
  logic                        emit_x;
  logic                        emit_w;
  logic                        stall;
  logic [btas_pkg::ADDR_W-1:0] step_amt;
  logic [btas_pkg::ADDR_W-1:0] in_step;
  logic [btas_pkg::ADDR_W-1:0] offset;
  logic [btas_pkg::ADDR_W-1:0] wb_val;

  btas_useq u_useq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  assign in_base = s_axis_tdata[31:0];
  assign in_breg = s_axis_tdata[35:32];
  assign in_list = s_axis_tdata[51:36];
  assign in_pre  = s_axis_tdata[52];
  assign in_up   = s_axis_tdata[53];
  assign in_wb   = s_axis_tdata[54];

  assign s_axis_tready = ctrl.take_in && !rst;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign ridx      = up ? pos : LAST_POS - pos;
  assign sel       = list[ridx];
  assign list_rest = list & ~(NUM_REGS'(1) << ridx);

  assign out_free = !m_valid || m_axis_tready;
  assign emit_x   = ctrl.emit_xfer && sel;
  assign emit_w   = ctrl.emit_wb && wb;
  assign stall    = (emit_x || emit_w) && !out_free;

  assign step_amt = up ? 32'd4 : 32'hFFFF_FFFC;
  assign in_step  = in_up ? 32'd4 : 32'hFFFF_FFFC;
  assign offset   = btas_pkg::ADDR_W'(count) << 2;
  assign wb_val   = up ? base + offset : base - offset;

  always_comb begin
    stat.accept    = accept;
    stat.scan_done = (pos == LAST_POS) || (list_rest == '0);
    stat.stall     = stall;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op    <= s_axis_tuser;
      base  <= in_base;
      breg  <= in_breg;
      list  <= in_list[NUM_REGS-1:0];
      up    <= in_up;
      wb    <= in_wb;
      pos   <= '0;
      count <= '0;
      addr  <= in_pre ? in_base + in_step : in_base;
    end else if (ctrl.emit_xfer && !stall) begin
      pos <= pos + PW'(1);
      if (sel) begin
        list  <= list_rest;
        addr  <= addr + step_amt;
        count <= count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if ((emit_x || emit_w) && out_free) begin
      m_valid <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_x && out_free) begin
      m_kind <= op ? btas_pkg::KIND_STORE : btas_pkg::KIND_LOAD;
      m_reg  <= btas_pkg::REG_W'(ridx);
      m_addr <= addr;
      m_last <= (list_rest == '0) && !wb;
    end else if (emit_w && out_free) begin
      m_kind <= btas_pkg::KIND_WB;
      m_reg  <= breg;
      m_addr <= wb_val;
      m_last <= 1'b1;
    end
  end

  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = {4'b0000, m_addr, m_reg};
  assign m_axis_tuser  = m_kind;
  assign m_axis_tlast  = m_last;

endmodule

[hw/rtl/btas_useq.sv]
`timescale 1ns / 1ps

module btas_useq (
  input  logic                  clk,
  input  logic                  rst,
  input  btas_pkg::useq_stat_t  stat,
  output btas_pkg::ucode_t      ctrl
);

  btas_pkg::step_t step;
  btas_pkg::step_t step_next;

  always_comb begin
    ctrl = btas_pkg::ucode_rom(step);
  end

  always_comb begin
    step_next = step;
    if (!stat.stall) begin
      unique case (ctrl.cond)
        btas_pkg::JC_ALWAYS: step_next = ctrl.target;
        btas_pkg::JC_ACCEPT: begin
          if (stat.accept) step_next = ctrl.target;
        end
        btas_pkg::JC_SCAN_DONE: begin
          if (stat.scan_done) step_next = ctrl.target;
        end
        default: step_next = btas_pkg::STEP_ACCEPT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= btas_pkg::STEP_ACCEPT;
    end else begin
      step <= step_next;
    end
  end

endmodule

[hw/rtl/btas_chk.sv]
`timescale 1ns / 1ps

`include "block_transfer_address_sequencer_core_assert.svh"

module btas_chk (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [btas_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic [1:0]                     m_axis_tuser,
  input logic                           m_axis_tlast
);

  `BTAS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
  `BTAS_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `BTAS_ASSERT_NOW(a_no_accept_midrun, m_axis_tvalid && !m_axis_tlast, !s_axis_tready)
  `BTAS_ASSERT_NOW(a_wb_is_last, m_axis_tvalid && (m_axis_tuser == btas_pkg::KIND_WB), m_axis_tlast)

endmodule

bind block_transfer_address_sequencer_core btas_chk u_btas_chk (.*);

[bench/block_transfer_address_sequencer_core_tb.sv]
`timescale 1ns / 1ps

module block_transfer_address_sequencer_core_tb;

  localparam int NUM_REGS    = btas_pkg::NUM_REGS_DEF;
  localparam int RAND_ITEMS  = 100;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int TAIL_CYCLES = 40;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_STORE = 1'b1;

  typedef struct {
    logic        op;
    logic [31:0] base_value;
    logic [3:0]  base_reg;
    logic [15:0] reg_mask;
    logic        pre_index;
    logic        up;
    logic        writeback;
    logic        hold_for_drain;
  } xfer_req_t;

  typedef struct {
    btas_pkg::kind_t kind;
    logic [3:0]      reg_index;
    logic [31:0]     addr_or_value;
    logic            is_last;
  } xfer_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [btas_pkg::S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic                           s_axis_tuser  = 1'b0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [btas_pkg::M_TDATA_W-1:0] m_axis_tdata;
  logic [1:0]                     m_axis_tuser;
  logic                           m_axis_tlast;

  xfer_req_t  pending_reqs[$];
  xfer_word_t expected_words[$];
  xfer_req_t  cur_req;
  logic       in_taken = 1'b0;
  int         gap_left = 0;
  int         calm_left = 0;
  int         stall_left = 0;
  int         quiet_left = 0;
  int         errors = 0;
  int         cycle_count = 0;

  block_transfer_address_sequencer_core #(.NUM_REGS(NUM_REGS)) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Expand one request into the words it should produce.
  function automatic void expand_request(xfer_req_t q);
    logic [31:0] addr;
    logic [31:0] stride;
    logic [31:0] offs;
    xfer_word_t  w;
    int          count;
    int          total;
    int          n;
    int          r;
    count = 0;
    n = 0;
    for (int i = 0; i < NUM_REGS; i++) begin
      if (q.reg_mask[i]) count++;
    end
    total = count + (q.writeback ? 1 : 0);
    if (total == 0) return;
    stride = q.up ? 32'd4 : 32'hFFFF_FFFC;
    addr = q.pre_index ? q.base_value + stride : q.base_value;
    for (int i = 0; i < NUM_REGS; i++) begin
      r = q.up ? i : NUM_REGS - 1 - i;
      if (q.reg_mask[r]) begin
        w.kind = (q.op == OP_STORE) ? btas_pkg::KIND_STORE : btas_pkg::KIND_LOAD;
        w.reg_index = r[3:0];
        w.addr_or_value = addr;
        w.is_last = (n + 1 == total);
        expected_words.push_back(w);
        n++;
        addr = addr + stride;
      end
    end
    if (q.writeback) begin
      offs = 32'(count * 4);
      w.kind = btas_pkg::KIND_WB;
      w.reg_index = q.base_reg;
      w.addr_or_value = q.up ? q.base_value + offs : q.base_value - offs;
      w.is_last = 1'b1;
      expected_words.push_back(w);
    end
  endfunction

  function automatic int pick_gap();
    int p;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    p = $urandom_range(0, 99);
    if (p < 5) calm_left = $urandom_range(5, 20);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int pick_stall();
    int p;
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    p = $urandom_range(0, 99);
    if (p < 3) quiet_left = $urandom_range(20, 60);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic add_req(logic op, logic [31:0] base_value, logic [3:0] base_reg,
                         logic [15:0] reg_mask, logic pre_index, logic up,
                         logic writeback, logic hold_for_drain);
    xfer_req_t q;
    q.op = op;
    q.base_value = base_value;
    q.base_reg = base_reg;
    q.reg_mask = reg_mask;
    q.pre_index = pre_index;
    q.up = up;
    q.writeback = writeback;
    q.hold_for_drain = hold_for_drain;
    pending_reqs.push_back(q);
  endtask

  function automatic logic [15:0] rand_list();
    int p;
    logic [15:0] v;
    p = $urandom_range(0, 99);
    v = '0;
    if (p < 10) return '0;
    if (p < 35) begin
      repeat ($urandom_range(1, 3)) v[$urandom_range(0, 15)] = 1'b1;
      return v;
    end
    if (p < 48) return 16'hFFFF ^ (16'h1 << $urandom_range(0, 15));
    if (p < 50) return 16'hFFFF;
    return 16'($urandom_range(0, 16'hFFFF));
  endfunction

  function automatic logic [31:0] rand_base();
    int p;
    p = $urandom_range(0, 99);
    if (p < 10) return $urandom_range(0, 63);
    if (p < 20) return 32'hFFFF_FFFF - $urandom_range(0, 63);
    return $urandom();
  endfunction

  // Stimulus source
  always @(negedge clk) begin
    xfer_req_t nxt;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_taken) begin
      in_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_reqs.size() > 0 &&
                   !(pending_reqs[0].hold_for_drain && expected_words.size() != 0)) begin
        nxt = pending_reqs.pop_front();
        cur_req = nxt;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= nxt.op;
        s_axis_tdata <= {1'b0, nxt.writeback, nxt.up, nxt.pre_index, nxt.reg_mask,
                         nxt.base_reg, nxt.base_value};
        gap_left = pick_gap();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result sink backpressure
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      stall_left = pick_stall();
    end
  end

  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      in_taken = 1'b1;
      expand_request(cur_req);
    end
  end

  always @(posedge clk) begin
    xfer_word_t exp_w;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_words.size() == 0) begin
        $error("unexpected word: kind %0d reg %0d addr %h last %0b", m_axis_tuser,
               m_axis_tdata[3:0], m_axis_tdata[35:4], m_axis_tlast);
        errors++;
      end else begin
        exp_w = expected_words.pop_front();
        if (m_axis_tuser !== exp_w.kind) begin
          $error("kind: expected %0d, got %0d", exp_w.kind, m_axis_tuser);
          errors++;
        end
        if (m_axis_tdata[3:0] !== exp_w.reg_index) begin
          $error("reg_index: expected %0d, got %0d", exp_w.reg_index, m_axis_tdata[3:0]);
          errors++;
        end
        if (m_axis_tdata[35:4] !== exp_w.addr_or_value) begin
          $error("address_or_value: expected %h, got %h", exp_w.addr_or_value,
                 m_axis_tdata[35:4]);
          errors++;
        end
        if (m_axis_tlast !== exp_w.is_last) begin
          $error("last: expected %0b, got %0b", exp_w.is_last, m_axis_tlast);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    // extremes, wrap, empty lists, every walk mode
    add_req(OP_LOAD,  32'h0000_0000, 4'd0,  16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b0);
    add_req(OP_STORE, 32'h0000_0000, 4'd15, 16'hFFFF, 1'b1, 1'b0, 1'b1, 1'b0);
    add_req(OP_LOAD,  32'hFFFF_FFC0, 4'd1,  16'hFFFF, 1'b0, 1'b1, 1'b0, 1'b0);
    add_req(OP_STORE, 32'h0000_0000, 4'd2,  16'hFFFF, 1'b0, 1'b0, 1'b1, 1'b0);
    add_req(OP_LOAD,  32'h1234_5678, 4'd4,  16'h0000, 1'b1, 1'b1, 1'b0, 1'b0);
    add_req(OP_STORE, 32'hFFFF_FFFF, 4'd8,  16'h0000, 1'b0, 1'b0, 1'b0, 1'b0);
    add_req(OP_LOAD,  32'h1234_5678, 4'd7,  16'h0000, 1'b1, 1'b1, 1'b1, 1'b0);
    add_req(OP_STORE, 32'h8765_4321, 4'd9,  16'h0000, 1'b0, 1'b0, 1'b1, 1'b0);
    add_req(OP_LOAD,  32'hFFFF_FFFC, 4'd6,  16'h0001, 1'b1, 1'b1, 1'b0, 1'b0);
    add_req(OP_STORE, 32'h0000_0000, 4'd11, 16'h8000, 1'b1, 1'b0, 1'b1, 1'b0);
    add_req(OP_LOAD,  32'h0000_0010, 4'd12, 16'h0001, 1'b0, 1'b0, 1'b0, 1'b0);
    add_req(OP_STORE, 32'hFFFF_FFF8, 4'd13, 16'h8000, 1'b0, 1'b1, 1'b1, 1'b0);
    add_req(OP_LOAD,  32'h0000_1000, 4'd3,  16'h0008, 1'b1, 1'b1, 1'b1, 1'b0);
    add_req(OP_STORE, 32'h0000_2000, 4'd14, 16'h8001, 1'b1, 1'b1, 1'b1, 1'b0);
    add_req(OP_STORE, 32'h0000_2000, 4'd14, 16'h8001, 1'b0, 1'b1, 1'b1, 1'b0);
    add_req(OP_STORE, 32'h0000_2000, 4'd14, 16'h8001, 1'b1, 1'b0, 1'b1, 1'b0);
    add_req(OP_STORE, 32'h0000_2000, 4'd14, 16'h8001, 1'b0, 1'b0, 1'b1, 1'b0);
    add_req(OP_STORE, 32'hAAAA_AAAA, 4'd10, 16'hAAAA, 1'b0, 1'b1, 1'b1, 1'b0);
    add_req(OP_LOAD,  32'h5555_5555, 4'd5,  16'h5555, 1'b1, 1'b0, 1'b1, 1'b1);
    add_req(OP_LOAD,  32'hFFFF_FFFF, 4'd15, 16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b0);
    for (int k = 0; k < RAND_ITEMS; k++) begin
      add_req(1'($urandom_range(0, 1)), rand_base(), 4'($urandom_range(0, 15)),
              rand_list(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
              ($urandom_range(0, 9) < 6), ($urandom_range(0, 19) == 0));
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() != 0 || s_axis_tvalid || expected_words.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
